>>> rtl/core/ncs_pkg.sv
// Shared types, codes and helpers for the NAND command sequencer.
package ncs_pkg;

    // Field widths
    localparam int MODE_W  = 3;
    localparam int BLOCK_W = 10;
    localparam int PAGE_W  = 5;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int KIND_W  = 3;
    localparam int CNT_W   = 10;
    localparam int STEP_W  = 3;

    // Parameter defaults
    localparam int PAGE_BYTES_DEFAULT = 528;
    localparam int PAGE_SHIFT_DEFAULT = 5;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Request modes
    localparam logic [MODE_W-1:0] MODE_READ_ID    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RESET      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ERASE      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ_PAGE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PROG_PAGE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FLASH_BYTE = 3'd5;
    localparam logic [MODE_W-1:0] MODE_HOST_BYTE  = 3'd6;

    // Bus cycle kinds
    localparam logic [KIND_W-1:0] CK_CMD    = 3'd0;
    localparam logic [KIND_W-1:0] CK_ADDR   = 3'd1;
    localparam logic [KIND_W-1:0] CK_WRITE  = 3'd2;
    localparam logic [KIND_W-1:0] CK_STROBE = 3'd3;
    localparam logic [KIND_W-1:0] CK_WAIT   = 3'd4;
    localparam logic [KIND_W-1:0] CK_HOST   = 3'd5;

    // Flash command opcodes
    localparam logic [BYTE_W-1:0] CMD_READ_ID = 8'h90;
    localparam logic [BYTE_W-1:0] CMD_RESET   = 8'hff;
    localparam logic [BYTE_W-1:0] CMD_ERASE1  = 8'h60;
    localparam logic [BYTE_W-1:0] CMD_ERASE2  = 8'hd0;
    localparam logic [BYTE_W-1:0] CMD_STATUS  = 8'h70;
    localparam logic [BYTE_W-1:0] CMD_READ    = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_PROG1   = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_PROG2   = 8'h10;
    localparam logic [BYTE_W-1:0] ADDR_COLUMN = 8'h00;

    // Operation tracked by the front
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_ID,
        OP_ERASE_WAIT,
        OP_READ_WAIT,
        OP_READ_DATA,
        OP_PROG_DATA,
        OP_PROG_WAIT,
        OP_STATUS
    } op_state_t;

    // Bus sequence templates expanded by the back
    typedef enum logic [3:0] {
        J_RESET,
        J_ID,
        J_ERASE,
        J_READ,
        J_PROG,
        J_STROBE,
        J_HOST,
        J_HOST_STROBE,
        J_WRITE,
        J_WRITE_COMMIT,
        J_STATUS_CMD
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [BYTE_W-1:0]  byte_lo;
        logic [BYTE_W-1:0]  byte_hi;
        logic [WORD_W-1:0]  word;
        logic               outcome;
        logic               last;
    } job_t;

    typedef struct packed {
        logic [KIND_W-1:0]  cycle_kind;
        logic [BYTE_W-1:0]  bus_byte;
        logic [WORD_W-1:0]  host_word;
        logic               outcome;
        logic               last;
    } res_t;

    // Number of results a job expands into
    function automatic logic [STEP_W-1:0] job_len(input job_kind_t kind);
        logic [STEP_W-1:0] len;
        unique case (kind)
            J_RESET:        len = 3'd2;
            J_ID:           len = 3'd3;
            J_ERASE:        len = 3'd5;
            J_READ:         len = 3'd5;
            J_PROG:         len = 3'd4;
            J_STROBE:       len = 3'd1;
            J_HOST:         len = 3'd1;
            J_HOST_STROBE:  len = 3'd2;
            J_WRITE:        len = 3'd1;
            J_WRITE_COMMIT: len = 3'd3;
            J_STATUS_CMD:   len = 3'd2;
            default:        len = 3'd1;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/core/ncs_front.sv
// Front part: accepts requests and flash/host bytes, tracks the operation, queues jobs.
module ncs_front
    import ncs_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEFAULT,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [MODE_W-1:0]  mode,
    input  logic [BLOCK_W-1:0] block_number,
    input  logic [PAGE_W-1:0]  page_number,
    input  logic [BYTE_W-1:0]  data_byte,
    output logic               push,
    output job_t               push_job
);

    localparam logic [CNT_W-1:0] PAGE_LIMIT = CNT_W'(PAGE_BYTES);

    op_state_t         state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] id_high_reg, id_high_next;
    logic [CNT_W-1:0]  count_inc;
    logic [WORD_W-1:0] block_ext;
    logic [WORD_W-1:0] row_block;
    logic [WORD_W-1:0] row_page;

    // Row address: block shifted up, page added, top bits dropped
    assign block_ext = WORD_W'(block_number);
    assign row_block = block_ext << PAGE_SHIFT;
    assign row_page  = row_block + WORD_W'(page_number);
    assign count_inc = count_reg + 1'b1;

    // Hold operation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= OP_IDLE;
            count_reg   <= '0;
            id_high_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            id_high_reg <= id_high_next;
        end
    end

    // Classify the request and pick the job
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        id_high_next = id_high_reg;
        push         = 1'b0;
        push_job     = '0;
        push_job.kind = J_STROBE;
        if (accept)
        begin
            unique case (mode)
                MODE_RESET:
                begin
                    push          = 1'b1;
                    push_job.kind = J_RESET;
                    push_job.last = 1'b1;
                    state_next    = OP_IDLE;
                    count_next    = '0;
                end
                MODE_READ_ID, MODE_ERASE, MODE_READ_PAGE, MODE_PROG_PAGE:
                begin
                    if (state_reg == OP_IDLE)
                    begin
                        push       = 1'b1;
                        count_next = '0;
                        unique case (mode)
                            MODE_READ_ID:
                            begin
                                push_job.kind = J_ID;
                                state_next    = OP_ID;
                            end
                            MODE_ERASE:
                            begin
                                push_job.kind    = J_ERASE;
                                push_job.byte_lo = row_block[7:0];
                                push_job.byte_hi = row_block[15:8];
                                state_next       = OP_ERASE_WAIT;
                            end
                            MODE_READ_PAGE:
                            begin
                                push_job.kind    = J_READ;
                                push_job.byte_lo = row_page[7:0];
                                push_job.byte_hi = row_page[15:8];
                                state_next       = OP_READ_WAIT;
                            end
                            default:
                            begin
                                push_job.kind    = J_PROG;
                                push_job.byte_lo = row_page[7:0];
                                push_job.byte_hi = row_page[15:8];
                                state_next       = OP_PROG_DATA;
                            end
                        endcase
                    end
                end
                MODE_HOST_BYTE:
                begin
                    if (state_reg == OP_PROG_DATA)
                    begin
                        push             = 1'b1;
                        push_job.byte_lo = data_byte;
                        if (count_inc >= PAGE_LIMIT)
                        begin
                            push_job.kind = J_WRITE_COMMIT;
                            state_next    = OP_PROG_WAIT;
                            count_next    = '0;
                        end
                        else
                        begin
                            push_job.kind = J_WRITE;
                            count_next    = count_inc;
                        end
                    end
                end
                MODE_FLASH_BYTE:
                begin
                    unique case (state_reg)
                        OP_ID:
                        begin
                            push = 1'b1;
                            if (count_reg == '0)
                            begin
                                push_job.kind = J_STROBE;
                                id_high_next  = data_byte;
                                count_next    = CNT_W'(1);
                            end
                            else
                            begin
                                push_job.kind = J_HOST;
                                push_job.word = {id_high_reg, data_byte};
                                push_job.last = 1'b1;
                                state_next    = OP_IDLE;
                                count_next    = '0;
                            end
                        end
                        OP_ERASE_WAIT, OP_PROG_WAIT:
                        begin
                            push          = 1'b1;
                            push_job.kind = J_STATUS_CMD;
                            state_next    = OP_STATUS;
                        end
                        OP_STATUS:
                        begin
                            push             = 1'b1;
                            push_job.kind    = J_HOST;
                            push_job.outcome = data_byte[0];
                            push_job.last    = 1'b1;
                            state_next       = OP_IDLE;
                            count_next       = '0;
                        end
                        OP_READ_WAIT:
                        begin
                            push          = 1'b1;
                            push_job.kind = J_STROBE;
                            state_next    = OP_READ_DATA;
                            count_next    = '0;
                        end
                        OP_READ_DATA:
                        begin
                            push          = 1'b1;
                            push_job.word = WORD_W'(data_byte);
                            if (count_inc >= PAGE_LIMIT)
                            begin
                                push_job.kind = J_HOST;
                                push_job.last = 1'b1;
                                state_next    = OP_IDLE;
                                count_next    = '0;
                            end
                            else
                            begin
                                push_job.kind = J_HOST_STROBE;
                                count_next    = count_inc;
                            end
                        end
                        default:
                        begin
                            // drop bytes nobody is waiting for
                        end
                    endcase
                end
                default:
                begin
                    // drop undefined modes
                end
            endcase
        end
    end

endmodule

>>> rtl/core/ncs_queue.sv
// Short job queue that decouples the front from the back.
module ncs_queue
    import ncs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   fill_reg;
    logic                do_push;
    logic                do_pop;

    assign full       = (fill_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/ncs_back.sv
// Back part: expands queued jobs into bus cycles and host results, one per cycle while the output is taken.
module ncs_back
    import ncs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic head_valid,
    input  job_t head_job,
    output logic pop,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    res_t              res_reg;
    res_t              cur_res;
    logic              load;
    logic              last_step;

    assign load      = !valid_reg || out_ready;
    assign last_step = (step_reg == job_len(head_job.kind) - 1'b1);
    assign pop       = load && head_valid && last_step;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Select the result for the current step of the head job
    always_comb
    begin
        cur_res = '0;
        unique case (head_job.kind)
            J_RESET:
            begin
                if (step_reg == 3'd0)
                begin
                    cur_res.cycle_kind = CK_CMD;
                    cur_res.bus_byte   = CMD_RESET;
                end
                else
                begin
                    cur_res.cycle_kind = CK_HOST;
                    cur_res.last       = 1'b1;
                end
            end
            J_ID:
            begin
                unique case (step_reg)
                    3'd0:
                    begin
                        cur_res.cycle_kind = CK_CMD;
                        cur_res.bus_byte   = CMD_READ_ID;
                    end
                    3'd1:
                    begin
                        cur_res.cycle_kind = CK_ADDR;
                        cur_res.bus_byte   = ADDR_COLUMN;
                    end
                    default:
                    begin
                        cur_res.cycle_kind = CK_STROBE;
                    end
                endcase
            end
            J_ERASE:
            begin
                unique case (step_reg)
                    3'd0:
                    begin
                        cur_res.cycle_kind = CK_CMD;
                        cur_res.bus_byte   = CMD_ERASE1;
                    end
                    3'd1:
                    begin
                        cur_res.cycle_kind = CK_ADDR;
                        cur_res.bus_byte   = head_job.byte_lo;
                    end
                    3'd2:
                    begin
                        cur_res.cycle_kind = CK_ADDR;
                        cur_res.bus_byte   = head_job.byte_hi;
                    end
                    3'd3:
                    begin
                        cur_res.cycle_kind = CK_CMD;
                        cur_res.bus_byte   = CMD_ERASE2;
                    end
                    default:
                    begin
                        cur_res.cycle_kind = CK_WAIT;
                    end
                endcase
            end
            J_READ, J_PROG:
            begin
                unique case (step_reg)
                    3'd0:
                    begin
                        cur_res.cycle_kind = CK_CMD;
                        cur_res.bus_byte   = (head_job.kind == J_READ) ? CMD_READ : CMD_PROG1;
                    end
                    3'd1:
                    begin
                        cur_res.cycle_kind = CK_ADDR;
                        cur_res.bus_byte   = ADDR_COLUMN;
                    end
                    3'd2:
                    begin
                        cur_res.cycle_kind = CK_ADDR;
                        cur_res.bus_byte   = head_job.byte_lo;
                    end
                    3'd3:
                    begin
                        cur_res.cycle_kind = CK_ADDR;
                        cur_res.bus_byte   = head_job.byte_hi;
                    end
                    default:
                    begin
                        cur_res.cycle_kind = CK_WAIT;
                    end
                endcase
            end
            J_STROBE:
            begin
                cur_res.cycle_kind = CK_STROBE;
            end
            J_HOST:
            begin
                cur_res.cycle_kind = CK_HOST;
                cur_res.host_word  = head_job.word;
                cur_res.outcome    = head_job.outcome;
                cur_res.last       = head_job.last;
            end
            J_HOST_STROBE:
            begin
                if (step_reg == 3'd0)
                begin
                    cur_res.cycle_kind = CK_HOST;
                    cur_res.host_word  = head_job.word;
                end
                else
                begin
                    cur_res.cycle_kind = CK_STROBE;
                end
            end
            J_WRITE:
            begin
                cur_res.cycle_kind = CK_WRITE;
                cur_res.bus_byte   = head_job.byte_lo;
            end
            J_WRITE_COMMIT:
            begin
                unique case (step_reg)
                    3'd0:
                    begin
                        cur_res.cycle_kind = CK_WRITE;
                        cur_res.bus_byte   = head_job.byte_lo;
                    end
                    3'd1:
                    begin
                        cur_res.cycle_kind = CK_CMD;
                        cur_res.bus_byte   = CMD_PROG2;
                    end
                    default:
                    begin
                        cur_res.cycle_kind = CK_WAIT;
                    end
                endcase
            end
            J_STATUS_CMD:
            begin
                if (step_reg == 3'd0)
                begin
                    cur_res.cycle_kind = CK_CMD;
                    cur_res.bus_byte   = CMD_STATUS;
                end
                else
                begin
                    cur_res.cycle_kind = CK_STROBE;
                end
            end
            default:
            begin
                cur_res = '0;
            end
        endcase
    end

    // Advance the step and output valid
    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                step_next = last_step ? '0 : step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            res_reg <= cur_res;
        end
    end

endmodule

>>> rtl/core/nand_command_sequencer_core.sv
// A request's job is written into the job queue, and its first result is then registered in
// the back part's result register before it is presented. Results leave at one per cycle while
// the receiver is ready; a job stays at the head of the queue until its last result is loaded.
// The four-entry job queue sets how far the front may run ahead of the back.
// Reset: asynchronous, active low; returns to idle, empties the queue, clears counts.
module nand_command_sequencer_core
    import ncs_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEFAULT,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // block_number[9:0], page_number[14:10], data_byte[22:15], pad
    input  logic [2:0]  s_tuser,   // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // bus_byte[7:0], host_word[23:8], outcome[24], pad
    output logic [2:0]  m_tuser,   // cycle_kind[2:0]
    output logic        m_tlast    // last
);

    logic accept;
    logic push;
    job_t push_job;
    logic full;
    logic pop;
    logic head_valid;
    job_t head_job;
    res_t out_res;

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;

    // Classify requests
    ncs_front #(
        .PAGE_BYTES (PAGE_BYTES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .mode         (s_tuser),
        .block_number (s_tdata[9:0]),
        .page_number  (s_tdata[14:10]),
        .data_byte    (s_tdata[22:15]),
        .push         (push),
        .push_job     (push_job)
    );

    // Buffer jobs
    ncs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Expand jobs into results
    ncs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    assign m_tdata = {7'b0, out_res.outcome, out_res.host_word, out_res.bus_byte};
    assign m_tuser = out_res.cycle_kind;
    assign m_tlast = out_res.last;

endmodule

>>> tb/sv/tb_nand_command_sequencer_core.sv
// Self-checking stream testbench for the NAND command sequencer core.
module tb_nand_command_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ncs_pkg::*;

    localparam int PAGE_BYTES   = PAGE_BYTES_DEFAULT;
    localparam int PAGE_SHIFT   = PAGE_SHIFT_DEFAULT;
    localparam int RANDOM_ITEMS = 460;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    // Mode code with no meaning to the block
    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // block_number[9:0], page_number[14:10], data_byte[22:15], pad
    logic [2:0]  s_tuser  = '0;   // mode[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // bus_byte[7:0], host_word[23:8], outcome[24], pad
    logic [2:0]  m_tuser;         // cycle_kind[2:0]
    logic        m_tlast;

    // Sequencer state mirrored by the predictor
    op_state_t         seq_op      = OP_IDLE;
    logic [CNT_W-1:0]  seq_count   = '0;
    logic [BYTE_W-1:0] seq_id_high = '0;
    res_t              expected_cycles[$];

    int send_gap_pct  = 0;
    int take_gap_pct  = 0;
    int effective_items = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int stall_asked   = 0;
    int stall_taken   = 0;
    int stall_left    = 0;

    nand_command_sequencer_core #(
        .PAGE_BYTES (PAGE_BYTES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Abort the run if it runs past the cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_nand_command_sequencer_core: errors");
            $finish;
        end
    end

    // Drive output ready: random gaps, or a long hold when one is requested
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (stall_taken != stall_asked)
        begin
            stall_taken = stall_asked;
            stall_left  = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= take_gap_pct);
        end
    end

    function automatic void queue_cycle(input logic [KIND_W-1:0] kind,
                                        input logic [BYTE_W-1:0] bus,
                                        input logic [WORD_W-1:0] word,
                                        input logic outcome,
                                        input logic last);
        res_t c;
        c.cycle_kind = kind;
        c.bus_byte   = bus;
        c.host_word  = word;
        c.outcome    = outcome;
        c.last       = last;
        expected_cycles.push_back(c);
    endfunction

    // Expand one request into the bus cycles and host results it causes
    function automatic int sequence_request(input logic [MODE_W-1:0] mode,
                                            input logic [BLOCK_W-1:0] blk,
                                            input logic [PAGE_W-1:0] page,
                                            input logic [BYTE_W-1:0] data);
        logic [15:0] row_block;
        logic [15:0] row_page;
        int          queued;
        row_block = 16'(blk) << PAGE_SHIFT;
        row_page  = row_block + 16'(page);
        queued    = expected_cycles.size();
        case (mode)
            MODE_RESET:
            begin
                queue_cycle(CK_CMD, CMD_RESET, '0, 1'b0, 1'b0);
                queue_cycle(CK_HOST, '0, '0, 1'b0, 1'b1);
                seq_op    = OP_IDLE;
                seq_count = '0;
            end
            MODE_READ_ID, MODE_ERASE, MODE_READ_PAGE, MODE_PROG_PAGE:
            begin
                // new operations only start from idle
                if (seq_op == OP_IDLE)
                begin
                    seq_count = '0;
                    if (mode == MODE_READ_ID)
                    begin
                        queue_cycle(CK_CMD, CMD_READ_ID, '0, 1'b0, 1'b0);
                        queue_cycle(CK_ADDR, ADDR_COLUMN, '0, 1'b0, 1'b0);
                        queue_cycle(CK_STROBE, '0, '0, 1'b0, 1'b0);
                        seq_op = OP_ID;
                    end
                    else if (mode == MODE_ERASE)
                    begin
                        queue_cycle(CK_CMD, CMD_ERASE1, '0, 1'b0, 1'b0);
                        queue_cycle(CK_ADDR, row_block[7:0], '0, 1'b0, 1'b0);
                        queue_cycle(CK_ADDR, row_block[15:8], '0, 1'b0, 1'b0);
                        queue_cycle(CK_CMD, CMD_ERASE2, '0, 1'b0, 1'b0);
                        queue_cycle(CK_WAIT, '0, '0, 1'b0, 1'b0);
                        seq_op = OP_ERASE_WAIT;
                    end
                    else
                    begin
                        queue_cycle(CK_CMD, (mode == MODE_READ_PAGE) ? CMD_READ : CMD_PROG1,
                                    '0, 1'b0, 1'b0);
                        queue_cycle(CK_ADDR, ADDR_COLUMN, '0, 1'b0, 1'b0);
                        queue_cycle(CK_ADDR, row_page[7:0], '0, 1'b0, 1'b0);
                        queue_cycle(CK_ADDR, row_page[15:8], '0, 1'b0, 1'b0);
                        if (mode == MODE_READ_PAGE)
                        begin
                            queue_cycle(CK_WAIT, '0, '0, 1'b0, 1'b0);
                            seq_op = OP_READ_WAIT;
                        end
                        else
                        begin
                            seq_op = OP_PROG_DATA;
                        end
                    end
                end
            end
            MODE_HOST_BYTE:
            begin
                if (seq_op == OP_PROG_DATA)
                begin
                    queue_cycle(CK_WRITE, data, '0, 1'b0, 1'b0);
                    seq_count = seq_count + 1'b1;
                    if (seq_count >= PAGE_BYTES)
                    begin
                        queue_cycle(CK_CMD, CMD_PROG2, '0, 1'b0, 1'b0);
                        queue_cycle(CK_WAIT, '0, '0, 1'b0, 1'b0);
                        seq_op    = OP_PROG_WAIT;
                        seq_count = '0;
                    end
                end
            end
            MODE_FLASH_BYTE:
            begin
                case (seq_op)
                    OP_ID:
                    begin
                        if (seq_count == '0)
                        begin
                            seq_id_high = data;
                            seq_count   = CNT_W'(1);
                            queue_cycle(CK_STROBE, '0, '0, 1'b0, 1'b0);
                        end
                        else
                        begin
                            queue_cycle(CK_HOST, '0, {seq_id_high, data}, 1'b0, 1'b1);
                            seq_op    = OP_IDLE;
                            seq_count = '0;
                        end
                    end
                    OP_ERASE_WAIT, OP_PROG_WAIT:
                    begin
                        // ready indication: data ignored, ask for status
                        queue_cycle(CK_CMD, CMD_STATUS, '0, 1'b0, 1'b0);
                        queue_cycle(CK_STROBE, '0, '0, 1'b0, 1'b0);
                        seq_op = OP_STATUS;
                    end
                    OP_STATUS:
                    begin
                        queue_cycle(CK_HOST, '0, '0, data[0], 1'b1);
                        seq_op    = OP_IDLE;
                        seq_count = '0;
                    end
                    OP_READ_WAIT:
                    begin
                        queue_cycle(CK_STROBE, '0, '0, 1'b0, 1'b0);
                        seq_op    = OP_READ_DATA;
                        seq_count = '0;
                    end
                    OP_READ_DATA:
                    begin
                        seq_count = seq_count + 1'b1;
                        if (seq_count >= PAGE_BYTES)
                        begin
                            queue_cycle(CK_HOST, '0, 16'(data), 1'b0, 1'b1);
                            seq_op    = OP_IDLE;
                            seq_count = '0;
                        end
                        else
                        begin
                            queue_cycle(CK_HOST, '0, 16'(data), 1'b0, 1'b0);
                            queue_cycle(CK_STROBE, '0, '0, 1'b0, 1'b0);
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return expected_cycles.size() - queued;
    endfunction

    // Compare each accepted result with the oldest expectation
    function automatic void check_bus_cycle();
        res_t got;
        res_t want;
        logic bad;
        got.cycle_kind = m_tuser;
        got.bus_byte   = m_tdata[7:0];
        got.host_word  = m_tdata[23:8];
        got.outcome    = m_tdata[24];
        got.last       = m_tlast;
        if (expected_cycles.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("unexpected result: kind %0d bus %02h word %04h outcome %0b last %0b",
                         got.cycle_kind, got.bus_byte, got.host_word, got.outcome, got.last);
        end
        else
        begin
            want = expected_cycles.pop_front();
            bad = (got.cycle_kind !== want.cycle_kind) || (got.bus_byte !== want.bus_byte) ||
                  (got.host_word !== want.host_word) || (got.outcome !== want.outcome) ||
                  (got.last !== want.last);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: kind %0d/%0d bus %02h/%02h word %04h/%04h %s %0b/%0b %s",
                             want.cycle_kind, got.cycle_kind, want.bus_byte, got.bus_byte,
                             want.host_word, got.host_word, "outcome", want.outcome, got.outcome,
                             $sformatf("last %0b/%0b (expected/actual)", want.last, got.last));
            end
        end
    endfunction

    // Outputs are stable at the falling edge; a handshake there lands on the next rise
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_bus_cycle();
    end

    // Offer one request, with a random gap first, and hold it until taken
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [BLOCK_W-1:0] blk,
                                input logic [PAGE_W-1:0] page,
                                input logic [BYTE_W-1:0] data);
        logic taken;
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, data, page, blk};
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_tready;
            if (taken && sequence_request(mode, blk, page, data) > 0)
                effective_items++;
            @(posedge clk);
        end
    endtask

    task automatic send_flash(input logic [BYTE_W-1:0] data);
        send_request(MODE_FLASH_BYTE, 10'($urandom), 5'($urandom), data);
    endtask

    task automatic send_host(input logic [BYTE_W-1:0] data);
        send_request(MODE_HOST_BYTE, 10'($urandom), 5'($urandom), data);
    endtask

    task automatic send_reset();
        send_request(MODE_RESET, 10'($urandom), 5'($urandom), 8'($urandom));
    endtask

    task automatic send_noise();
        send_request(3'($urandom), 10'($urandom), 5'($urandom), 8'($urandom));
    endtask

    task automatic set_pacing(input int send_pct, input int take_pct);
        send_gap_pct = send_pct;
        take_gap_pct = take_pct;
    endtask

    // Field extremes, every operation and the ignored-request cases
    task automatic test_directed_requests();
        send_request(MODE_RESET, 10'h3ff, 5'h1f, 8'hff);
        // device id, high byte first
        send_request(MODE_READ_ID, 10'h000, 5'h00, 8'h00);
        send_request(MODE_FLASH_BYTE, 10'h3ff, 5'h1f, 8'hff);
        send_request(MODE_FLASH_BYTE, 10'h000, 5'h00, 8'h00);
        // erase top block; busy request, stray host byte and spare mode drop
        send_request(MODE_ERASE, 10'h3ff, 5'h1f, 8'h5a);
        send_request(MODE_READ_ID, 10'h3ff, 5'h1f, 8'hff);
        send_request(MODE_HOST_BYTE, 10'h3ff, 5'h1f, 8'hff);
        send_request(MODE_SPARE, 10'h3ff, 5'h1f, 8'hff);
        send_request(MODE_FLASH_BYTE, 10'h000, 5'h00, 8'h00);
        send_request(MODE_FLASH_BYTE, 10'h000, 5'h00, 8'h01);
        // erase block zero, status bit clear
        send_request(MODE_ERASE, 10'h000, 5'h00, 8'h00);
        send_request(MODE_FLASH_BYTE, 10'h000, 5'h00, 8'hff);
        send_request(MODE_FLASH_BYTE, 10'h3ff, 5'h1f, 8'hfe);
        // read the top page of the top block, abort with reset
        send_request(MODE_READ_PAGE, 10'h3ff, 5'h1f, 8'h00);
        send_request(MODE_FLASH_BYTE, 10'h000, 5'h00, 8'h00);
        send_request(MODE_FLASH_BYTE, 10'h155, 5'h0a, 8'ha5);
        send_request(MODE_RESET, 10'h000, 5'h00, 8'h00);
        // program page zero, busy request ignored, abort with reset
        send_request(MODE_PROG_PAGE, 10'h000, 5'h00, 8'h00);
        send_request(MODE_HOST_BYTE, 10'h000, 5'h00, 8'h00);
        send_request(MODE_HOST_BYTE, 10'h2aa, 5'h15, 8'hff);
        send_request(MODE_PROG_PAGE, 10'h3ff, 5'h1f, 8'h00);
        send_request(MODE_RESET, 10'h3ff, 5'h1f, 8'hff);
        // stray bytes while idle
        send_request(MODE_FLASH_BYTE, 10'h3ff, 5'h1f, 8'h3c);
        send_request(MODE_HOST_BYTE, 10'h000, 5'h00, 8'hc3);
    endtask

    // Mostly whole or cut-short sequences with random content, some noise
    task automatic test_random_traffic(input int target);
        int goal;
        int pick;
        int k;
        int i;
        logic [MODE_W-1:0] op_mode;
        goal = effective_items + target;
        while (effective_items < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 52 && seq_op != OP_IDLE)
                send_reset();
            if (pick < 14)
            begin
                send_request(MODE_READ_ID, 10'($urandom), 5'($urandom), 8'($urandom));
                send_flash(8'($urandom));
                send_flash(8'($urandom));
            end
            else if (pick < 28)
            begin
                send_request(MODE_ERASE, 10'($urandom), 5'($urandom), 8'($urandom));
                send_flash(8'($urandom));
                send_flash(8'($urandom));
            end
            else if (pick < 40)
            begin
                send_request(MODE_READ_PAGE, 10'($urandom), 5'($urandom), 8'($urandom));
                send_flash(8'($urandom));
                k = $urandom_range(1, 16);
                for (i = 0; i < k; i++)
                    send_flash(8'($urandom));
            end
            else if (pick < 52)
            begin
                send_request(MODE_PROG_PAGE, 10'($urandom), 5'($urandom), 8'($urandom));
                k = $urandom_range(1, 16);
                for (i = 0; i < k; i++)
                    send_host(8'($urandom));
            end
            else if (pick < 60)
            begin
                send_reset();
            end
            else if (pick < 80)
            begin
                // start an operation, then break it up with arbitrary items
                case ($urandom_range(3))
                    0:       op_mode = MODE_READ_ID;
                    1:       op_mode = MODE_ERASE;
                    2:       op_mode = MODE_READ_PAGE;
                    default: op_mode = MODE_PROG_PAGE;
                endcase
                send_request(op_mode, 10'($urandom), 5'($urandom), 8'($urandom));
                k = $urandom_range(1, 4);
                for (i = 0; i < k; i++)
                    send_noise();
            end
            else
            begin
                k = $urandom_range(1, 3);
                for (i = 0; i < k; i++)
                    send_noise();
            end
        end
    endtask

    // Full program and read of one page, with stray requests mixed in
    task automatic test_full_pages();
        int i;
        if (seq_op != OP_IDLE)
            send_reset();
        send_request(MODE_PROG_PAGE, 10'($urandom), 5'($urandom), 8'($urandom));
        for (i = 0; i < PAGE_BYTES; i++)
        begin
            if (i == PAGE_BYTES / 2)
            begin
                send_request(MODE_ERASE, 10'($urandom), 5'($urandom), 8'($urandom));
                send_flash(8'($urandom));
            end
            send_host(8'($urandom));
        end
        send_flash(8'($urandom));
        send_host(8'($urandom));
        send_flash(8'($urandom));
        send_request(MODE_READ_PAGE, 10'($urandom), 5'($urandom), 8'($urandom));
        send_flash(8'($urandom));
        for (i = 0; i < PAGE_BYTES; i++)
        begin
            if (i == PAGE_BYTES / 3)
            begin
                send_request(MODE_PROG_PAGE, 10'($urandom), 5'($urandom), 8'($urandom));
                send_host(8'($urandom));
            end
            send_flash(8'($urandom));
        end
        // block must be idle again
        send_request(MODE_READ_ID, 10'($urandom), 5'($urandom), 8'($urandom));
        send_flash(8'($urandom));
        send_flash(8'($urandom));
    endtask

    // Hold the receiver off while read data keeps coming, so the input stalls
    task automatic test_receiver_hold();
        int i;
        if (seq_op != OP_IDLE)
            send_reset();
        send_request(MODE_READ_PAGE, 10'($urandom), 5'($urandom), 8'($urandom));
        send_flash(8'($urandom));
        stall_asked++;
        for (i = 0; i < 40; i++)
            send_flash(8'($urandom));
        send_reset();
    endtask

    initial
    begin
        set_pacing(16, 46);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_requests();
        test_random_traffic(RANDOM_ITEMS / 3);

        set_pacing(46, 16);
        test_full_pages();
        test_random_traffic(RANDOM_ITEMS / 3);

        set_pacing(0, 0);
        test_receiver_hold();
        test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        // drain
        s_tvalid <= 1'b0;
        while (expected_cycles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_cycles.size() == 0)
            $display("tb_nand_command_sequencer_core: clean");
        else
            $display("tb_nand_command_sequencer_core: errors");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/ncs_pkg.sv
rtl/core/ncs_front.sv
rtl/core/ncs_queue.sv
rtl/core/ncs_back.sv
rtl/core/nand_command_sequencer_core.sv
tb/sv/tb_nand_command_sequencer_core.sv
